// ----- sv/srnc_pkg.sv -----
// ----------------------------------------------------------------------------
// srnc_pkg: shared definitions for the radius neighbour counter
// Widths, default parameter values and command codes.
// ----------------------------------------------------------------------------
package srnc_pkg;

	localparam int RADIUS_BITS    = 23;
	localparam int COUNT_BITS     = 13;
	localparam int REF_DEPTH_DEF  = 4096;
	localparam int COORD_BITS_DEF = 24;

	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_QUERY  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_REWIND = 2'd3;

endpackage

// ----- sv/srnc_ref_mem.sv -----
// ----------------------------------------------------------------------------
// srnc_ref_mem: reference point memory
// One write port and one read port with registered read data; each word
// holds the x and y coordinates of one reference point.
// ----------------------------------------------------------------------------
module srnc_ref_mem
	import srnc_pkg::*;
#(
	parameter int REF_DEPTH  = REF_DEPTH_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF,
	localparam int AW = $clog2(REF_DEPTH)
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  logic [COORD_BITS-1:0] wr_x,
	input  logic [COORD_BITS-1:0] wr_y,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output logic [COORD_BITS-1:0] rd_x,
	output logic [COORD_BITS-1:0] rd_y
);

	logic [2*COORD_BITS-1:0] mem [REF_DEPTH];
	logic [2*COORD_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_x, wr_y};
		end
	end

	// The read word holds until the next read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_x = rd_data_q[2*COORD_BITS-1:COORD_BITS];
	assign rd_y = rd_data_q[COORD_BITS-1:0];

endmodule

// ----- sv/srnc_sq_unit.sv -----
// ----------------------------------------------------------------------------
// srnc_sq_unit: shared squaring unit
// One multiplier squares the selected operand; the product is captured either
// as the squared radius or as the working product.
// ----------------------------------------------------------------------------
module srnc_sq_unit
	import srnc_pkg::*;
(
	input  logic                     clk,
	input  logic [RADIUS_BITS-1:0]   op,
	input  logic                     load_r2,
	input  logic                     load_prod,
	output logic [2*RADIUS_BITS-1:0] r2_q,
	output logic [2*RADIUS_BITS-1:0] prod_q
);

	logic [2*RADIUS_BITS-1:0] sq;

	assign sq = (2*RADIUS_BITS)'(op) * (2*RADIUS_BITS)'(op);

	always_ff @(posedge clk) begin
		if (load_r2) begin
			r2_q <= sq;
		end
		if (load_prod) begin
			prod_q <= sq;
		end
	end

endmodule

// ----- sv/sorted_radius_neighbour_count.sv -----
// ----------------------------------------------------------------------------
// sorted_radius_neighbour_count: fixed radius neighbour counter, 2-D sweep
// Stores x-sorted reference points and counts those within the radius of
// each query by a forward window scan through the reference memory.
// ----------------------------------------------------------------------------
// Append, clear and rewind words complete while idle; busy stays low.
// A query runs from start to the done strobe through ST_R2, then ST_ADV for
// each window advance and ST_CHECK for each entry scanned; each entry in the box
// is squared by the shared unit in ST_SQX and ST_SQY and summed in ST_ACC.
// Empty set: done comes in the cycle after start. The memory read port and the
// squaring unit set the per-entry pace. done cannot be held off by the receiver.
// Reset clears the point count, window start, radius and the sequencer.
// ----------------------------------------------------------------------------
module sorted_radius_neighbour_count
	import srnc_pkg::*;
#(
	parameter int REF_DEPTH  = REF_DEPTH_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         radius_we,
	input  logic [RADIUS_BITS-1:0]       radius,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   cmd,
	input  logic signed [COORD_BITS-1:0] x_coord,
	input  logic signed [COORD_BITS-1:0] y_coord,
	output logic                         done,
	output logic [COUNT_BITS-1:0]        neighbour_count
);

	localparam int AW  = $clog2(REF_DEPTH);
	localparam int CW  = $clog2(REF_DEPTH + 1);
	localparam int MW  = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
	localparam int EXT = MW + 2;
	localparam int SW  = 2*RADIUS_BITS + 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_R2    = 3'd1;
	localparam logic [2:0] ST_ADV   = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_SQX   = 3'd4;
	localparam logic [2:0] ST_SQY   = 3'd5;
	localparam logic [2:0] ST_ACC   = 3'd6;

	logic [2:0]                   state_q;
	logic [RADIUS_BITS-1:0]       radius_q;
	logic [CW-1:0]                ref_count_q;
	logic [AW-1:0]                ws_q;
	logic [AW-1:0]                idx_q;
	logic [COUNT_BITS-1:0]        cnt_q;
	logic [COUNT_BITS-1:0]        out_cnt_q;
	logic                         done_q;
	logic signed [COORD_BITS-1:0] qx_q;
	logic signed [COORD_BITS-1:0] qy_q;
	logic signed [EXT-1:0]        qlo_q;
	logic signed [EXT-1:0]        qhi_q;
	logic [RADIUS_BITS-1:0]       adx_q;
	logic [RADIUS_BITS-1:0]       ady_q;
	logic [2*RADIUS_BITS-1:0]     sqx_q;

	logic                         accept;
	logic                         wr_en;
	logic                         rd_en;
	logic [AW-1:0]                rd_addr;
	logic [COORD_BITS-1:0]        rd_x;
	logic [COORD_BITS-1:0]        rd_y;
	logic [AW-1:0]                ws_clamp;
	logic [CW-1:0]                ws_inc;
	logic [CW-1:0]                idx_inc;
	logic                         adv;
	logic                         have_next;
	logic signed [EXT-1:0]        x_ext;
	logic signed [EXT-1:0]        dx;
	logic signed [EXT-1:0]        dy;
	logic [EXT-1:0]               adx;
	logic [EXT-1:0]               ady;
	logic [EXT-1:0]               r_ext;
	logic                         past_hi;
	logic                         in_box;
	logic [RADIUS_BITS-1:0]       sq_op;
	logic                         load_r2;
	logic                         load_prod;
	logic [2*RADIUS_BITS-1:0]     r2_q;
	logic [2*RADIUS_BITS-1:0]     prod_q;
	logic [SW-1:0]                dist2;
	logic                         hit;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign neighbour_count = out_cnt_q;

	assign wr_en = accept && (cmd == CMD_APPEND) && (ref_count_q < CW'(REF_DEPTH));

	srnc_ref_mem #(
		.REF_DEPTH  (REF_DEPTH),
		.COORD_BITS (COORD_BITS)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (ref_count_q[AW-1:0]),
		.wr_x    (x_coord),
		.wr_y    (y_coord),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_x    (rd_x),
		.rd_y    (rd_y)
	);

	srnc_sq_unit u_sq (
		.clk       (clk),
		.op        (sq_op),
		.load_r2   (load_r2),
		.load_prod (load_prod),
		.r2_q      (r2_q),
		.prod_q    (prod_q)
	);

	// Window start is pulled back to the last stored entry before a query if it lies past it.
	assign ws_clamp  = (CW'(ws_q) >= ref_count_q) ? AW'(ref_count_q - CW'(1)) : ws_q;
	assign ws_inc    = CW'(ws_q) + CW'(1);
	assign idx_inc   = CW'(idx_q) + CW'(1);
	assign have_next = (idx_inc < ref_count_q);

	assign x_ext   = EXT'($signed(rd_x));
	assign dx      = x_ext - EXT'(qx_q);
	assign dy      = EXT'($signed(rd_y)) - EXT'(qy_q);
	assign adx     = dx[EXT-1] ? EXT'(-dx) : EXT'(dx);
	assign ady     = dy[EXT-1] ? EXT'(-dy) : EXT'(dy);
	assign r_ext   = EXT'(radius_q);
	assign adv     = (ws_inc < ref_count_q) && (x_ext < qlo_q);
	assign past_hi = (x_ext >= qhi_q);
	assign in_box  = (ady < r_ext) && (adx < r_ext);

	assign dist2 = SW'(sqx_q) + SW'(prod_q);
	assign hit   = (dist2 < SW'(r2_q));

	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = ws_clamp;
		sq_op     = radius_q;
		load_r2   = 1'b0;
		load_prod = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				rd_en = accept && (cmd == CMD_QUERY) && (ref_count_q != '0);
			end
			ST_R2: begin
				load_r2 = 1'b1;
			end
			ST_ADV: begin
				rd_en   = adv;
				rd_addr = ws_inc[AW-1:0];
			end
			ST_CHECK: begin
				rd_en   = !past_hi && !in_box && have_next;
				rd_addr = idx_inc[AW-1:0];
			end
			ST_SQX: begin
				sq_op     = adx_q;
				load_prod = 1'b1;
			end
			ST_SQY: begin
				sq_op     = ady_q;
				load_prod = 1'b1;
			end
			ST_ACC: begin
				rd_en   = have_next;
				rd_addr = idx_inc[AW-1:0];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
		end else if (radius_we) begin
			radius_q <= radius;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ref_count_q <= '0;
			ws_q        <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd)
							CMD_APPEND: begin
								if (wr_en) begin
									ref_count_q <= ref_count_q + CW'(1);
								end
							end
							CMD_QUERY: begin
								if (ref_count_q == '0) begin
									done_q <= 1'b1;
								end else begin
									ws_q    <= ws_clamp;
									state_q <= ST_R2;
								end
							end
							CMD_CLEAR: begin
								ref_count_q <= '0;
								ws_q        <= '0;
							end
							CMD_REWIND: begin
								ws_q <= '0;
							end
							default: begin
								ws_q <= ws_q;
							end
						endcase
					end
				end
				ST_R2: begin
					state_q <= ST_ADV;
				end
				ST_ADV: begin
					if (adv) begin
						ws_q <= ws_inc[AW-1:0];
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (past_hi || (!in_box && !have_next)) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (in_box) begin
						state_q <= ST_SQX;
					end
				end
				ST_SQX: begin
					state_q <= ST_SQY;
				end
				ST_SQY: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (have_next) begin
						state_q <= ST_CHECK;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; the count word follows the running count in CHECK and ACC and is cleared in idle.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				qx_q      <= x_coord;
				qy_q      <= y_coord;
				cnt_q     <= '0;
				out_cnt_q <= '0;
			end
			ST_R2: begin
				qlo_q <= EXT'(qx_q) - $signed(r_ext);
				qhi_q <= EXT'(qx_q) + $signed(r_ext);
			end
			ST_ADV: begin
				if (!adv) begin
					idx_q <= ws_q;
				end
			end
			ST_CHECK: begin
				adx_q     <= RADIUS_BITS'(adx);
				ady_q     <= RADIUS_BITS'(ady);
				out_cnt_q <= cnt_q;
				if (!past_hi && !in_box && have_next) begin
					idx_q <= idx_inc[AW-1:0];
				end
			end
			ST_SQX: begin
				sqx_q <= sqx_q;
			end
			ST_SQY: begin
				sqx_q <= prod_q;
			end
			ST_ACC: begin
				if (hit) begin
					cnt_q     <= cnt_q + COUNT_BITS'(1);
					out_cnt_q <= cnt_q + COUNT_BITS'(1);
				end else begin
					out_cnt_q <= cnt_q;
				end
				if (have_next) begin
					idx_q <= idx_inc[AW-1:0];
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

endmodule

// ----- tb/sorted_radius_neighbour_count_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_radius_neighbour_count_tb: self-checking bench for the neighbour counter
// Drives append, query, clear and rewind words with random gaps, keeps its own
// model of the stored set, window and radius, and checks every count that the
// block returns against the model, oldest first.
// ----------------------------------------------------------------------------
module sorted_radius_neighbour_count_tb;
	import srnc_pkg::*;

	localparam longint COORD_MAX  = 64'sd8388607;
	localparam longint COORD_MIN  = -64'sd8388608;
	localparam longint RADIUS_MAX = 64'sd8388607;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         radius_we = 1'b0;
	logic [RADIUS_BITS-1:0]       radius = '0;
	logic                         start = 1'b0;
	logic                         busy;
	logic [1:0]                   cmd = CMD_APPEND;
	logic signed [COORD_BITS_DEF-1:0] x_coord = '0;
	logic signed [COORD_BITS_DEF-1:0] y_coord = '0;
	logic                         done;
	logic [COUNT_BITS-1:0]        neighbour_count;

	// Model of the block.
	longint      stored_x [REF_DEPTH_DEF];
	longint      stored_y [REF_DEPTH_DEF];
	int unsigned stored_count = 0;
	int unsigned window_lo = 0;
	longint      radius_setting = 0;

	logic [COUNT_BITS-1:0] expected_counts [$];
	logic [COUNT_BITS-1:0] want;
	int unsigned errors = 0;
	bit          no_idle = 1'b0;

	sorted_radius_neighbour_count DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.radius_we      (radius_we),
		.radius         (radius),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.x_coord        (x_coord),
		.y_coord        (y_coord),
		.done           (done),
		.neighbour_count(neighbour_count)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic longint clamp_coord(input longint v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return v;
	endfunction

	function automatic longint coord_near(input longint c, input longint spread);
		return clamp_coord(c + longint'($urandom_range(0, 2 * spread)) - spread);
	endfunction

	function automatic longint coord_any();
		return longint'($urandom_range(0, 32'hFFFFFF)) + COORD_MIN;
	endfunction

	function automatic longint abs_diff(input longint a, input longint b);
		return (a >= b) ? a - b : b - a;
	endfunction

	// Sweeps the window forward and counts the stored points strictly inside
	// the radius. The window start is moved as a side effect.
	function automatic logic [COUNT_BITS-1:0] count_neighbours(input longint qx,
			input longint qy);
		longint      r;
		longint      adx;
		longint      ady;
		int unsigned idx;
		int unsigned hits;
		r = radius_setting;
		hits = 0;
		if (stored_count > 0) begin
			if (window_lo >= stored_count)
				window_lo = stored_count - 1;
			while (window_lo + 1 < stored_count && stored_x[window_lo] < qx - r)
				window_lo++;
			for (idx = window_lo; idx < stored_count; idx++) begin
				if (stored_x[idx] >= qx + r)
					break;
				ady = abs_diff(stored_y[idx], qy);
				adx = abs_diff(stored_x[idx], qx);
				if (ady < r && adx < r && adx * adx + ady * ady < r * r)
					hits++;
			end
		end
		return hits[COUNT_BITS-1:0];
	endfunction

	task automatic update_model(input logic [1:0] c, input longint x, input longint y);
		case (c)
			CMD_APPEND: begin
				if (stored_count < REF_DEPTH_DEF) begin
					stored_x[stored_count] = x;
					stored_y[stored_count] = y;
					stored_count++;
				end
			end
			CMD_QUERY: expected_counts.push_back(count_neighbours(x, y));
			CMD_CLEAR: begin
				stored_count = 0;
				window_lo = 0;
			end
			CMD_REWIND: window_lo = 0;
		endcase
	endtask

	// Presents one word after a random gap, none while no_idle is set, and waits until it is taken.
	task automatic send_word(input logic [1:0] c, input longint x, input longint y);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		x_coord <= x[COORD_BITS_DEF-1:0];
		y_coord <= y[COORD_BITS_DEF-1:0];
		do
			@(posedge clk);
		while (busy);
		update_model(c, longint'($signed(x[COORD_BITS_DEF-1:0])),
			longint'($signed(y[COORD_BITS_DEF-1:0])));
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (expected_counts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_radius(input logic [RADIUS_BITS-1:0] value);
		radius_we <= 1'b1;
		radius <= value;
		@(posedge clk);
		radius_setting = longint'(value);
		radius_we <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (done) begin
			if (expected_counts.size() == 0) begin
				errors++;
				$display("%0t: neighbour_count expected none, got %0d", $time,
					neighbour_count);
			end else begin
				want = expected_counts.pop_front();
				if (neighbour_count !== want) begin
					errors++;
					$display("%0t: neighbour_count expected %0d, got %0d", $time,
						want, neighbour_count);
				end
			end
		end
	end

	task automatic test_empty_set();
		send_word(CMD_QUERY, 0, 0);
		send_word(CMD_REWIND, COORD_MAX, COORD_MIN);
		send_word(CMD_CLEAR, COORD_MIN, COORD_MAX);
		wait_idle();
	endtask

	// Points placed exactly on, just inside and just outside the radius of 3.0.
	task automatic test_strict_boundaries();
		write_radius(23'h000300);
		send_word(CMD_APPEND, -'h300, 0);
		send_word(CMD_APPEND, -'h2FF, 0);
		send_word(CMD_APPEND, 0, 'h2FF);
		send_word(CMD_APPEND, 0, 'h300);
		send_word(CMD_APPEND, 'h1FF, 'h220);
		send_word(CMD_APPEND, 'h220, 'h220);
		send_word(CMD_APPEND, 'h300, 0);
		send_word(CMD_QUERY, 0, 0);
		send_word(CMD_QUERY, 'h300, 0);
		send_word(CMD_QUERY, COORD_MAX, COORD_MIN);
	endtask

	task automatic test_clear_rewind();
		send_word(CMD_REWIND, 0, 0);
		send_word(CMD_QUERY, 0, 0);
		send_word(CMD_CLEAR, 0, 0);
		send_word(CMD_QUERY, 0, 0);
		send_word(CMD_APPEND, COORD_MAX, COORD_MAX);
		send_word(CMD_QUERY, COORD_MAX, COORD_MAX);
		wait_idle();
	endtask

	task automatic test_extreme_radius();
		write_radius(RADIUS_MAX[RADIUS_BITS-1:0]);
		send_word(CMD_APPEND, COORD_MIN, COORD_MIN);
		send_word(CMD_QUERY, COORD_MIN, COORD_MIN);
		send_word(CMD_QUERY, COORD_MAX, COORD_MAX);
		wait_idle();
		write_radius('0);
		send_word(CMD_QUERY, COORD_MAX, COORD_MAX);
		wait_idle();
	endtask

	// Fills the store past its depth; the surplus words must be dropped.
	task automatic test_full_store();
		int unsigned i;
		no_idle = 1'b1;
		send_word(CMD_CLEAR, 0, 0);
		for (i = 0; i < REF_DEPTH_DEF + 4; i++)
			send_word(CMD_APPEND, -'h80000 + longint'(i) * 'h100,
				longint'($urandom_range(0, 'h800)) - 'h400);
		no_idle = 1'b0;
		wait_idle();
		write_radius(23'h000280);
		send_word(CMD_QUERY, 0, 0);
		send_word(CMD_QUERY, -'h80000 + 4095 * 'h100, 0);
		send_word(CMD_QUERY, -'h80000 + 4098 * 'h100, 'h100);
		send_word(CMD_QUERY, COORD_MAX, 0);
		send_word(CMD_REWIND, 0, 0);
		send_word(CMD_QUERY, -'h80000, 0);
		wait_idle();
		write_radius(23'h100000);
		send_word(CMD_QUERY, 0, 0);
		wait_idle();
	endtask

	// Sorted reference sets with ascending queries around a random center,
	// mixed with rewinds, stray words and pauses until results drain.
	task automatic test_random_sequences();
		int unsigned sent;
		int unsigned n_new;
		int unsigned n_queries;
		int unsigned k;
		longint      r;
		longint      spread;
		longint      step;
		longint      cx;
		longint      cy;
		longint      x;
		longint      qx;
		sent = 0;
		while (sent < 1350) begin
			wait_idle();
			case ($urandom_range(0, 9))
				0: r = 0;
				1: r = RADIUS_MAX;
				2, 3: r = longint'($urandom_range(1, 32'h7FFFFF));
				default: r = longint'($urandom_range(1, 32'h800));
			endcase
			write_radius(r[RADIUS_BITS-1:0]);
			no_idle = ($urandom_range(0, 3) == 0);
			spread = (r < 32) ? 64 : ((r > COORD_MAX / 2) ? COORD_MAX : 2 * r);
			cx = coord_any();
			cy = coord_any();
			if ($urandom_range(0, 4) != 0) begin
				send_word(CMD_CLEAR, coord_any(), coord_any());
				sent++;
			end
			n_new = $urandom_range(0, 24);
			step = (2 * spread) / (n_new + 1) + 1;
			x = clamp_coord(cx - spread);
			for (k = 0; k < n_new; k++) begin
				x = clamp_coord(x + longint'($urandom_range(0, step)));
				send_word(CMD_APPEND, x, coord_near(cy, spread));
				sent++;
			end
			n_queries = $urandom_range(1, 10);
			qx = clamp_coord(cx - spread - r);
			for (k = 0; k < n_queries; k++) begin
				case ($urandom_range(0, 11))
					0: begin
						send_word(CMD_REWIND, coord_any(), coord_any());
						qx = clamp_coord(cx - spread - r);
						sent++;
					end
					1: begin
						send_word(2'($urandom_range(0, 3)), coord_any(), coord_any());
						sent++;
					end
					2: wait_idle();
					default: ;
				endcase
				qx = clamp_coord(qx + longint'($urandom_range(0, 2 * step)));
				send_word(CMD_QUERY, qx, coord_near(cy, spread));
				sent++;
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_set();
		test_strict_boundaries();
		test_clear_rewind();
		test_extreme_radius();
		test_full_store();
		test_random_sequences();
		wait_idle();
		repeat (32) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
